// ===== rtl/rsame_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsame_pkg: shared types and constants of the modular exponentiation block
// Command and status bundles between controller and datapath, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package rsame_pkg;

  localparam int BLOCK_W   = 32;
  localparam int EXP_W     = 32;
  localparam int MUL_CNT_W = $clog2(BLOCK_W);

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_ENC_EXP = 2'd1;
  localparam logic [1:0] REG_DEC_EXP = 2'd2;

  // Operand selection of the modular multiplier.
  typedef enum logic [1:0] {
    MUL_REDUCE = 2'd0,
    MUL_ACC    = 2'd1,
    MUL_SQ     = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     shift_expo;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic expo_zero;
    logic expo_lsb;
    logic err;
  } sts_t;

endpackage : rsame_pkg
`default_nettype wire

// ===== rtl/rsa_block_modular_exponentiation_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_block_modular_exponentiation_top: RSA block modular exponentiation
// Raises a block to the public or private exponent modulo the modulus.
// ----------------------------------------------------------------------------
// Usage. Program modulus (address 0), encrypt_exponent (address 4) and
// decrypt_exponent (address 8) through the APB port while the block is idle;
// all three reset to zero and read back their written values. Each input
// transaction (req_type, block_value) yields exactly one output transaction
// (result_value, error_flag). The error flag is set, with a zero result,
// when the modulus is below two or a decrypt finds a zero private exponent.
// Only the low MOD_WIDTH bits of the modulus take part.
//
// Operation. The input is first reduced modulo n, then the exponent is walked
// from its least significant bit. Every modular multiplication runs on the
// single bit-serial unit; transactions are handled one at a time.
//
// Stalls and reset. The result sits in an output register; a new input is
// taken as soon as the datapath is free, even while that result is waiting.
// A finished result waits inside the controller until the output register
// drains. Synchronous reset clears the key registers, the sequencer and the
// output valid; no memory needs clearing.
// ----------------------------------------------------------------------------
module rsa_block_modular_exponentiation_top #(
  parameter int MOD_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         req_type,
  input  wire  [31:0] block_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] result_value,
  output logic        error_flag
);
  import rsame_pkg::*;

  logic [31:0] modulus;
  logic [31:0] encrypt_exponent;
  logic [31:0] decrypt_exponent;
  logic        cfg_write;

  cmd_t        cmd;
  sts_t        sts;
  logic        out_load;
  logic        out_free;
  logic [BLOCK_W-1:0] dp_result;
  logic        dp_err;

  // The APB port never inserts wait states; the register index is the word
  // address, so byte offsets within a word are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= '0;
      encrypt_exponent <= '0;
      decrypt_exponent <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_MODULUS: modulus          <= pwdata;
        REG_ENC_EXP: encrypt_exponent <= pwdata;
        REG_DEC_EXP: decrypt_exponent <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODULUS: prdata = modulus;
      REG_ENC_EXP: prdata = encrypt_exponent;
      REG_DEC_EXP: prdata = decrypt_exponent;
      default:     prdata = '0;
    endcase
  end

  // The output register frees up in the same cycle its transaction is taken.
  assign out_free = !out_valid || out_ready;

  rsame_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .out_load (out_load),
    .cmd      (cmd),
    .sts      (sts)
  );

  rsame_dp #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .n           (modulus[MOD_WIDTH-1:0]),
    .enc_exp     (encrypt_exponent),
    .dec_exp     (decrypt_exponent),
    .req_type    (req_type),
    .block_value (block_value),
    .result      (dp_result),
    .err_value   (dp_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= dp_result;
      error_flag   <= dp_err;
    end
  end

endmodule : rsa_block_modular_exponentiation_top
`default_nettype wire

// ===== rtl/rsame_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsame_dp: exponentiation datapath
// Holds base, accumulator and exponent, and a bit-serial modular multiplier
// that handles one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rsame_dp #(
  parameter int MOD_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  rsame_pkg::cmd_t          cmd,
  output rsame_pkg::sts_t          sts,
  input  wire [MOD_WIDTH-1:0]      n,
  input  wire [rsame_pkg::EXP_W-1:0] enc_exp,
  input  wire [rsame_pkg::EXP_W-1:0] dec_exp,
  input  wire                      req_type,
  input  wire [rsame_pkg::BLOCK_W-1:0] block_value,
  output logic [rsame_pkg::BLOCK_W-1:0] result,
  output logic                     err_value
);
  import rsame_pkg::*;

  logic [BLOCK_W-1:0]   base;
  logic [MOD_WIDTH-1:0] acc;
  logic [EXP_W-1:0]     expo;
  logic                 err;

  logic [BLOCK_W-1:0]   mul_a;
  logic [MOD_WIDTH-1:0] mul_b;
  logic [MOD_WIDTH-1:0] mul_r;
  logic [MUL_CNT_W-1:0] mul_cnt;
  logic                 mul_busy;
  logic                 mul_done;
  mul_sel_t             mul_dst;

  logic [BLOCK_W-1:0]   a_start;
  logic [MOD_WIDTH-1:0] b_start;
  logic [MOD_WIDTH+1:0] r2;
  logic [MOD_WIDTH+1:0] n1;
  logic [MOD_WIDTH+1:0] n2;
  logic [MOD_WIDTH+1:0] r_step;
  logic [MOD_WIDTH-1:0] r_new;
  logic                 last_step;
  logic                 load_err;

  assign load_err = (n[MOD_WIDTH-1:1] == '0) || (req_type && (dec_exp == '0));

  always_comb begin
    case (cmd.mul_sel)
      MUL_REDUCE: begin
        a_start = base;
        b_start = MOD_WIDTH'(1);
      end
      MUL_ACC: begin
        a_start = BLOCK_W'(acc);
        b_start = base[MOD_WIDTH-1:0];
      end
      MUL_SQ: begin
        a_start = base;
        b_start = base[MOD_WIDTH-1:0];
      end
      default: begin
        a_start = base;
        b_start = '0;
      end
    endcase
  end

  // One step of interleaved multiplication: r = (2r + bit*b) mod n, with
  // r and b below n, so the sum stays below 3n.
  always_comb begin
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    r2 = {1'b0, mul_r, 1'b0} + {2'b00, (mul_a[BLOCK_W-1] ? mul_b : '0)};
    if (r2 >= n2) begin
      r_step = r2 - n2;
    end else if (r2 >= n1) begin
      r_step = r2 - n1;
    end else begin
      r_step = r2;
    end
    r_new = r_step[MOD_WIDTH-1:0];
  end

  assign last_step = (mul_cnt == MUL_CNT_W'(BLOCK_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy <= 1'b1;
      end else if (mul_busy && last_step) begin
        mul_busy <= 1'b0;
        mul_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= block_value;
      acc  <= MOD_WIDTH'(1);
      expo <= req_type ? dec_exp : enc_exp;
      err  <= load_err;
    end
    if (cmd.shift_expo) begin
      expo <= expo >> 1;
    end
    if (cmd.mul_start) begin
      mul_a   <= a_start;
      mul_b   <= b_start;
      mul_r   <= '0;
      mul_cnt <= '0;
      mul_dst <= cmd.mul_sel;
    end else if (mul_busy) begin
      mul_a   <= mul_a << 1;
      mul_r   <= r_new;
      mul_cnt <= mul_cnt + MUL_CNT_W'(1);
      if (last_step) begin
        case (mul_dst)
          MUL_ACC: acc  <= r_new;
          default: base <= BLOCK_W'(r_new);
        endcase
      end
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.expo_zero = (expo == '0);
  assign sts.expo_lsb  = expo[0];
  assign sts.err       = err;

  assign result    = err ? '0 : BLOCK_W'(acc);
  assign err_value = err;

endmodule : rsame_dp
`default_nettype wire

// ===== rtl/rsame_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsame_ctrl: exponentiation sequencer
// Walks the exponent from its low end, ordering the multiplications of the
// datapath, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module rsame_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire             out_free,
  output logic            out_load,
  output rsame_pkg::cmd_t cmd,
  input  rsame_pkg::sts_t sts
);
  import rsame_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_START   = 6'b000010,
    ST_REDUCE  = 6'b000100,
    ST_CHECK   = 6'b001000,
    ST_MUL_ACC = 6'b010000,
    ST_MUL_SQ  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  // A finished or failed transaction waits in ST_IDLE-bound form: finish
  // marks the cycle in which the result is ready for the output register.
  logic   pending;
  logic   pending_next;

  always_comb begin
    state_next     = state;
    pending_next   = pending;
    cmd.load       = 1'b0;
    cmd.mul_start  = 1'b0;
    cmd.mul_sel    = MUL_REDUCE;
    cmd.shift_expo = 1'b0;
    finish         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (pending) begin
          if (out_free) begin
            finish       = 1'b1;
            pending_next = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.err) begin
          pending_next = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_REDUCE;
          state_next    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts.mul_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.expo_zero) begin
          pending_next = 1'b1;
          state_next   = ST_IDLE;
        end else if (sts.expo_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_ACC;
          state_next    = ST_MUL_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_SQ;
          state_next    = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_SQ;
          state_next    = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (sts.mul_done) begin
          cmd.shift_expo = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE) && !pending;
  assign out_load = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule : rsame_ctrl
`default_nettype wire

// ===== test/tb_rsa_block_modular_exponentiation_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rsa_block_modular_exponentiation_top: self-checking bench for RSA modexp
// Programs the key registers over APB (with read-back), sends encrypt and
// decrypt requests through the valid/ready input channel and compares every
// output transaction against a square-and-multiply predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_rsa_block_modular_exponentiation_top;
  import rsame_pkg::*;

  localparam int MOD_W = 32;

  // No correct run goes this long without a transaction on either channel,
  // not even the longest exponentiation plus a short output stall.
  localparam int STALL_LIMIT = 20000;

  // Quiet time after the last result, long enough for a stray extra result
  // from a full-length exponentiation to show up.
  localparam int DRAIN_CYCLES = 2200;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] blk;
  } request_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [31:0] block_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_value;
  logic        error_flag;

  rsa_block_modular_exponentiation_top #(
    .MOD_WIDTH(MOD_W)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .block_value (block_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_value(result_value),
    .error_flag  (error_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench copy of the key registers. They are only changed while the block
  // is idle, so the copy in force at input acceptance is the one the block uses.
  logic [31:0] key_n = '0;
  logic [31:0] key_e = '0;
  logic [31:0] key_d = '0;

  request_t    request_q[$];   // requests not yet presented to the block
  outcome_t    outcome_q[$];   // predicted results, oldest first

  bit          quiet = 1'b0;   // set for the last phase: no idling on either side
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_cycles = 0;

  int n_errors = 0;
  int n_requests = 0;
  int n_decrypt = 0;
  int n_results = 0;
  int n_flagged = 0;
  int n_settings = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Binary square-and-multiply, least significant exponent bit first. Both
  // operands stay below n < 2^32, so every product fits in 64 bits.
  function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] ex,
                                            logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [31:0] rest;
    acc  = 64'd1 % n;
    sq   = {32'd0, base} % n;
    rest = ex;
    while (rest != 32'd0) begin
      if (rest[0]) acc = (acc * sq) % n;
      sq   = (sq * sq) % n;
      rest = rest >> 1;
    end
    return acc[31:0];
  endfunction

  // A modulus below two is checked first and fails for both request kinds;
  // a decrypt also fails when no private exponent has been set.
  function automatic outcome_t predict_outcome(request_t rq);
    outcome_t    o;
    logic [63:0] n;
    logic [31:0] ex;
    n       = {32'd0, key_n} & ((64'd1 << MOD_W) - 64'd1);
    o.value = '0;
    o.err   = 1'b0;
    if (n < 64'd2) begin
      o.err = 1'b1;
    end else if (rq.kind == REQ_DECRYPT && key_d == 32'd0) begin
      o.err = 1'b1;
    end else begin
      ex      = (rq.kind == REQ_DECRYPT) ? key_d : key_e;
      o.value = power_mod(rq.blk, ex, n);
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. A new request is presented only when the channel is free,
  // and the payload holds until the transaction completes. After a transaction
  // the driver sometimes pauses for a random burst before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t sent;
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        sent.kind = req_type;
        sent.blk  = block_value;
        outcome_q = {outcome_q, predict_outcome(sent)};
        n_requests++;
        if (sent.kind == REQ_DECRYPT) n_decrypt++;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_valid    <= 1'b1;
          req_type    <= nxt.kind;
          block_value <= nxt.blk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each output transaction is checked field by field against
  // the oldest prediction. Back-pressure comes in random bursts, separated by
  // runs of cycles with ready held high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", result_value, 32'd0);
        end else begin
          want = outcome_q.pop_front();
          n_results++;
          if (want.err) n_flagged++;
          if (result_value !== want.value)
            report_mismatch("result_value", result_value, want.value);
          if (error_flag !== want.err)
            report_mismatch("error_flag", {31'd0, error_flag}, {31'd0, want.err});
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_stall = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung block shows up as a long stretch with no transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, outcome_q.size());
        $display("tb_rsa_block_modular_exponentiation_top: errors");
        $finish;
      end
    end
  end

  // One APB transfer: a setup cycle, then the access cycle, which ends at the
  // first rising edge that sees pready high. Read data is taken at that edge.
  task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes all three key registers, updates the bench copy and reads each
  // register back.
  task automatic program_key(logic [31:0] n, logic [31:0] e, logic [31:0] d);
    logic [31:0] back;
    apb_access(1'b1, REG_MODULUS, n, back);
    key_n = n;
    apb_access(1'b1, REG_ENC_EXP, e, back);
    key_e = e;
    apb_access(1'b1, REG_DEC_EXP, d, back);
    key_d = d;
    apb_access(1'b0, REG_MODULUS, 32'd0, back);
    if (back !== n) report_mismatch("modulus read-back", back, n);
    apb_access(1'b0, REG_ENC_EXP, 32'd0, back);
    if (back !== e) report_mismatch("encrypt_exponent read-back", back, e);
    apb_access(1'b0, REG_DEC_EXP, 32'd0, back);
    if (back !== d) report_mismatch("decrypt_exponent read-back", back, d);
    n_settings++;
  endtask

  task automatic queue_req(logic kind, logic [31:0] blk);
    request_t rq;
    rq.kind = kind;
    rq.blk  = blk;
    request_q = {request_q, rq};
  endtask

  // Idle means every request presented, accepted and answered. The check
  // runs on the falling edge, once the clocked blocks have settled.
  task automatic wait_idle();
    do @(negedge clk); while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  // Mostly full-width random moduli, with a share of tiny ones, ones near the
  // top of the range and the invalid values zero and one.
  function automatic logic [31:0] rand_modulus();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(2, 300);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_exponent();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd3;
      3:       return 32'd65537;
      4:       return $urandom_range(2, 255);
      default: return $urandom;
    endcase
  endfunction

  // Blocks at and around the modulus exercise the input reduction.
  function automatic logic [31:0] rand_block(logic [31:0] n);
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return n - 32'd1;
      2:       return n;
      3:       return 32'hFFFF_FFFF;
      4:       return (n > 32'd1) ? $urandom % n : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus. After the first, each phase programs a key while the block is
  // idle; every phase queues a batch of requests and waits until all are answered.
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int k;
    logic [31:0] n;
    logic [31:0] e;
    logic [31:0] d;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset value: the zero modulus flags every request.
    queue_req(REQ_ENCRYPT, 32'h0000_1234);
    queue_req(REQ_DECRYPT, 32'hFFFF_FFFF);
    wait_idle();

    // A modulus of one is just as invalid, even with both exponents set.
    program_key(32'd1, 32'd17, 32'd2753);
    queue_req(REQ_ENCRYPT, 32'd65);
    queue_req(REQ_DECRYPT, 32'd0);
    wait_idle();

    // Textbook key n = 61 * 53: the encrypt/decrypt pair round-trips, and
    // blocks at or above n are reduced first.
    program_key(32'd3233, 32'd17, 32'd2753);
    queue_req(REQ_ENCRYPT, 32'd65);
    queue_req(REQ_DECRYPT, 32'd2790);
    queue_req(REQ_ENCRYPT, 32'd0);
    queue_req(REQ_ENCRYPT, 32'hFFFF_FFFF);
    queue_req(REQ_DECRYPT, 32'd3233);
    queue_req(REQ_DECRYPT, 32'd3232);
    wait_idle();

    // Zero public exponent gives one; an unset private exponent is an error.
    program_key(32'd3233, 32'd0, 32'd0);
    queue_req(REQ_ENCRYPT, 32'd7);
    queue_req(REQ_DECRYPT, 32'd7);
    queue_req(REQ_ENCRYPT, 32'hFFFF_FFFF);
    wait_idle();

    // Exponent one must still return a reduced block.
    program_key(32'd3233, 32'd1, 32'd1);
    queue_req(REQ_ENCRYPT, 32'hFFFF_FFFF);
    queue_req(REQ_DECRYPT, 32'hDEAD_BEEF);
    wait_idle();

    // All-ones modulus and exponents: the widest operands and longest run.
    program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_ENCRYPT, 32'hFFFF_FFFE);
    queue_req(REQ_DECRYPT, 32'h1234_5678);
    queue_req(REQ_ENCRYPT, 32'hFFFF_FFFF);
    wait_idle();

    // Smallest valid modulus.
    program_key(32'd2, 32'h8000_0001, 32'd2);
    queue_req(REQ_ENCRYPT, 32'd3);
    queue_req(REQ_DECRYPT, 32'd2);
    wait_idle();

    // Random keys and blocks; the last phase runs with no idling at all.
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;
      n = rand_modulus();
      e = rand_exponent();
      d = ($urandom_range(0, 5) == 0) ? 32'd0 : rand_exponent();
      program_key(n, e, d);
      for (k = 0; k < 20; k++) queue_req(1'($urandom_range(0, 1)), rand_block(n));
      wait_idle();
    end

    // Any extra result during this window is caught by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d decrypt), %0d results checked, %0d flagged",
             n_requests, n_decrypt, n_results, n_flagged);
    $display("as errors, over %0d key settings; %0d mismatches.", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("tb_rsa_block_modular_exponentiation_top: clean");
    end else begin
      $display("tb_rsa_block_modular_exponentiation_top: errors");
    end
    $finish;
  end

endmodule : tb_rsa_block_modular_exponentiation_top
`default_nettype wire
